@@ sv/lpft_pkg.sv @@
package lpft_pkg;

    // default geometry
    localparam int COORD_WIDTH_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_LIMITS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION  = 3'd7;

    // reset values: identity rotation, no offset, limits wide open
    localparam logic [47:0] RST_ROT_ROW0    = 48'h0000_0000_4000;
    localparam logic [47:0] RST_ROT_ROW1    = 48'h0000_4000_0000;
    localparam logic [47:0] RST_ROT_ROW2    = 48'h4000_0000_0000;
    localparam logic [47:0] RST_TRANSLATION = 48'h0;
    localparam logic [35:0] RST_MIN_RANGE   = 36'h0;
    localparam logic [35:0] RST_MAX_RANGE   = 36'hF_FFFF_FFFF;
    localparam logic [47:0] RST_Z_LIMITS    = 48'h7F_FFFF_80_0000;
    localparam logic [7:0]  RST_DECIMATION  = 8'd1;

    // point classification
    localparam logic [7:0] TAG_QUAL_MASK = 8'h30;
    localparam logic [7:0] TAG_QUAL_HIGH = 8'h10;
    localparam logic [7:0] TAG_QUAL_NORM = 8'h00;
    localparam logic [7:0] LINE_LIMIT    = 8'd4;

    localparam int STRENGTH_W = 8;
    localparam int STAMP_W    = 64;
    localparam int REL_W      = 32;

    typedef struct packed {
        logic [47:0] rot_row0;
        logic [47:0] rot_row1;
        logic [47:0] rot_row2;
        logic [47:0] translation;
        logic [35:0] min_range_sq;
        logic [35:0] max_range_sq;
        logic [47:0] z_limits;
    } t_xform_cfg;

endpackage

@@ sv/lpft_if.sv @@
interface lpft_pt_if import lpft_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  frame_start;
    logic signed [CW-1:0]  x_in;
    logic signed [CW-1:0]  y_in;
    logic signed [CW-1:0]  z_in;
    logic [7:0]            reflectivity;
    logic [7:0]            point_tag;
    logic [7:0]            scan_line;
    logic [STAMP_W-1:0]    stamp_ns;

    modport source (
        output valid, frame_start, x_in, y_in, z_in, reflectivity, point_tag,
               scan_line, stamp_ns,
        input  ready
    );
    modport sink (
        input  valid, frame_start, x_in, y_in, z_in, reflectivity, point_tag,
               scan_line, stamp_ns,
        output ready
    );
endinterface

interface lpft_res_if import lpft_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic signed [CW-1:0]   x_out;
    logic signed [CW-1:0]   y_out;
    logic signed [CW-1:0]   z_out;
    logic [STRENGTH_W-1:0]  strength_out;
    logic [REL_W-1:0]       rel_time_ns;

    modport source (
        output valid, x_out, y_out, z_out, strength_out, rel_time_ns,
        input  ready
    );
    modport sink (
        input  valid, x_out, y_out, z_out, strength_out, rel_time_ns,
        output ready
    );
endinterface

interface lpft_cfg_if import lpft_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/lidar_point_filter_transform.sv @@
// lidar point filter and rigid transform
//
// i_pt carries one lidar point per request (valid/ready). o_res carries the
// surviving points, transformed, with their offset from the frame's base
// stamp. i_cfg writes one of eight registers per request and is always ready;
// it is meant to be written only while no point is in flight.
//
// the front part decimates and classifies each point in the cycle it is
// accepted and pushes kept points into a four-entry queue. the back part pops
// the queue into a five-register pipeline: products, rounded sums, translate
// and clamp, squares and z check, then range check into the output register.
// throughput is one point per cycle while o_res does not stall, set by the
// queue and pipeline each moving one entry a cycle. points dropped by the
// filters produce nothing. if o_res is stalled the output register holds,
// the pipeline and queue fill and only then does i_pt.ready fall.
// reset (synchronous, active low) restores the identity transform, open
// limits, decimation one, clears the decimation phase and frame base and
// empties the queue and pipeline.
module lidar_point_filter_transform import lpft_pkg::*; #(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpft_cfg_if.sink   i_cfg,
    lpft_pt_if.sink    i_pt,
    lpft_res_if.source o_res
);

    // queue entry: strength, relative time and the three raw coordinates
    localparam int EW = 3 * COORD_WIDTH + REL_W + STRENGTH_W;

    t_xform_cfg    r_cfg;
    logic [7:0]    r_decimation;

    logic          w_push;
    logic [EW-1:0] w_push_data;
    logic          w_q_ready;
    logic          w_q_valid;
    logic [EW-1:0] w_q_data;
    logic          w_q_pop;

    // register file; the user must write it only between frames of work, the block does not enforce this
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot_row0     <= RST_ROT_ROW0;
            r_cfg.rot_row1     <= RST_ROT_ROW1;
            r_cfg.rot_row2     <= RST_ROT_ROW2;
            r_cfg.translation  <= RST_TRANSLATION;
            r_cfg.min_range_sq <= RST_MIN_RANGE;
            r_cfg.max_range_sq <= RST_MAX_RANGE;
            r_cfg.z_limits     <= RST_Z_LIMITS;
            r_decimation       <= RST_DECIMATION;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ROT_ROW0:    r_cfg.rot_row0     <= i_cfg.data[47:0];
                CFG_ROT_ROW1:    r_cfg.rot_row1     <= i_cfg.data[47:0];
                CFG_ROT_ROW2:    r_cfg.rot_row2     <= i_cfg.data[47:0];
                CFG_TRANSLATION: r_cfg.translation  <= i_cfg.data[47:0];
                CFG_MIN_RANGE:   r_cfg.min_range_sq <= i_cfg.data[35:0];
                CFG_MAX_RANGE:   r_cfg.max_range_sq <= i_cfg.data[35:0];
                CFG_Z_LIMITS:    r_cfg.z_limits     <= i_cfg.data[47:0];
                CFG_DECIMATION:  r_decimation       <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

    // front: decimation, line and tag filters, frame base and time offset
    lpft_front #(
        .CW (COORD_WIDTH),
        .EW (EW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pt         (i_pt),
        .i_decimation (r_decimation),
        .i_q_ready    (w_q_ready),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    // short queue so the two halves stall independently
    lpft_queue #(
        .W     (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_q_pop)
    );

    // back: rotate, translate, clamp, then range and height limits
    lpft_back #(
        .CW   (COORD_WIDTH),
        .FRAC (COEF_FRAC_BITS),
        .EW   (EW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_q_pop),
        .o_res     (o_res)
    );

endmodule

@@ sv/lpft_front.sv @@
module lpft_front import lpft_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF,
    parameter int EW = 3 * CW + REL_W + STRENGTH_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lpft_pt_if.sink       i_pt,
    input  logic [7:0]    i_decimation,
    input  logic          i_q_ready,
    output logic          o_push,
    output logic [EW-1:0] o_push_data
);

    logic [7:0]         r_skip;
    logic [STAMP_W-1:0] r_base;
    logic [7:0]         n_skip;

    logic               w_accept;
    logic [7:0]         w_dec;
    logic [7:0]         w_skip_cur;
    logic [8:0]         w_skip_inc;
    logic [STAMP_W-1:0] w_base_cur;
    logic [STAMP_W:0]   w_diff;
    logic [REL_W-1:0]   w_rel;
    logic [7:0]         w_qual;
    logic               w_keep;

    assign i_pt.ready = i_q_ready;
    assign w_accept   = i_pt.valid && i_q_ready;

    // zero decimation behaves as one
    assign w_dec      = (i_decimation == 8'd0) ? 8'd1 : i_decimation;
    assign w_skip_cur = i_pt.frame_start ? 8'd0 : r_skip;
    assign w_skip_inc = {1'b0, w_skip_cur} + 9'd1;
    assign n_skip     = (w_skip_inc >= {1'b0, w_dec}) ? 8'd0 : w_skip_inc[7:0];

    assign w_qual = i_pt.point_tag & TAG_QUAL_MASK;
    assign w_keep = (w_skip_cur == 8'd0) && (i_pt.scan_line < LINE_LIMIT)
                 && ((w_qual == TAG_QUAL_HIGH) || (w_qual == TAG_QUAL_NORM));

    // offset from frame base, clamped at both ends
    assign w_base_cur = i_pt.frame_start ? i_pt.stamp_ns : r_base;
    assign w_diff     = {1'b0, i_pt.stamp_ns} - {1'b0, w_base_cur};

    always_comb begin
        if (w_diff[STAMP_W]) begin
            w_rel = '0;
        end else if (|w_diff[STAMP_W-1:REL_W]) begin
            w_rel = '1;
        end else begin
            w_rel = w_diff[REL_W-1:0];
        end
    end

    assign o_push      = w_accept && w_keep;
    assign o_push_data = {i_pt.reflectivity, w_rel, i_pt.z_in, i_pt.y_in, i_pt.x_in};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= '0;
            r_base <= '0;
        end else if (w_accept) begin
            r_skip <= n_skip;
            if (i_pt.frame_start) begin
                r_base <= i_pt.stamp_ns;
            end
        end
    end

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_pt.frame_start) |=>
            (r_skip <= 8'd1) && (r_base == $past(i_pt.stamp_ns)))
        else $error("frame start did not restart the decimation phase");

    a_push_selected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_pt.frame_start || r_skip == 8'd0))
        else $error("point pushed outside its decimation slot");

endmodule

@@ sv/lpft_queue.sv @@
module lpft_queue import lpft_pkg::*; #(
    parameter int W     = 3 * COORD_WIDTH_DEF + REL_W + STRENGTH_W,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    assign n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_ready || i_pop))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ sv/lpft_back.sv @@
module lpft_back import lpft_pkg::*; #(
    parameter int CW   = COORD_WIDTH_DEF,
    parameter int FRAC = COEF_FRAC_BITS_DEF,
    parameter int EW   = 3 * CW + REL_W + STRENGTH_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_xform_cfg    i_cfg,
    input  logic          i_q_valid,
    input  logic [EW-1:0] i_q_data,
    output logic          o_q_pop,
    lpft_res_if.source    o_res
);

    localparam int PW = CW + 16;
    localparam int AW = CW + 18;
    localparam int SW = CW + 19;
    localparam int QW = 2 * CW;
    localparam int DW = (QW + 2 > 36) ? QW + 2 : 36;
    localparam int ZW = (CW > 24) ? CW : 24;
    localparam logic signed [AW-1:0] RND_HALF = AW'(64'd1 << (FRAC - 1));

    logic signed [CW-1:0]  w_pt   [3];
    logic signed [15:0]    w_coef [3][3];
    logic signed [15:0]    w_trans[3];
    logic [47:0]           w_rows [3];

    // stage 1: products
    logic                  r_v1;
    logic signed [PW-1:0]  r_prod [3][3];
    logic [REL_W-1:0]      r_rel1;
    logic [7:0]            r_str1;
    // stage 2: rounded sums
    logic                  r_v2;
    logic signed [AW-1:0]  r_acc  [3];
    logic [REL_W-1:0]      r_rel2;
    logic [7:0]            r_str2;
    // stage 3: translated, saturated coordinates
    logic                  r_v3;
    logic signed [CW-1:0]  r_crd3 [3];
    logic [REL_W-1:0]      r_rel3;
    logic [7:0]            r_str3;
    // stage 4: squares and z check
    logic                  r_v4;
    logic [QW-1:0]         r_sq4  [3];
    logic signed [CW-1:0]  r_crd4 [3];
    logic                  r_zok4;
    logic [REL_W-1:0]      r_rel4;
    logic [7:0]            r_str4;
    // output register
    logic                  r_ov;
    logic signed [CW-1:0]  r_ocrd [3];
    logic [REL_W-1:0]      r_orel;
    logic [7:0]            r_ostr;

    logic                  w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_en_out;
    logic signed [SW-1:0]  w_sum  [3];
    logic signed [CW-1:0]  w_sat  [3];
    logic [CW-1:0]         w_mag  [3];
    logic signed [ZW-1:0]  w_zmin, w_zmax, w_z3;
    logic [DW-1:0]         w_d2;
    logic                  w_keep;

    assign w_pt[0] = i_q_data[CW-1:0];
    assign w_pt[1] = i_q_data[2*CW-1:CW];
    assign w_pt[2] = i_q_data[3*CW-1:2*CW];

    assign w_rows[0] = i_cfg.rot_row0;
    assign w_rows[1] = i_cfg.rot_row1;
    assign w_rows[2] = i_cfg.rot_row2;

    for (genvar gi = 0; gi < 3; gi++) begin : g_fields
        assign w_trans[gi] = i_cfg.translation[16*gi +: 16];
        for (genvar gc = 0; gc < 3; gc++) begin : g_coef
            assign w_coef[gi][gc] = w_rows[gi][16*gc +: 16];
        end
    end

    // elastic chain: a stage loads when it is empty or its content moves on
    assign w_en_out = !r_ov || o_res.ready;
    assign w_rdy4   = !r_v4 || w_en_out;
    assign w_rdy3   = !r_v3 || w_rdy4;
    assign w_rdy2   = !r_v2 || w_rdy3;
    assign w_rdy1   = !r_v1 || w_rdy2;
    assign o_q_pop  = i_q_valid && w_rdy1;

    // round, translate and clamp to the coordinate range
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = SW'(r_acc[i] >>> FRAC) + SW'(w_trans[i]);
            if ((&w_sum[i][SW-1:CW-1]) || !(|w_sum[i][SW-1:CW-1])) begin
                w_sat[i] = w_sum[i][CW-1:0];
            end else if (w_sum[i][SW-1]) begin
                w_sat[i] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                w_sat[i] = {1'b0, {(CW-1){1'b1}}};
            end
            w_mag[i] = r_crd3[i][CW-1] ? CW'(-r_crd3[i]) : CW'(r_crd3[i]);
        end
    end

    assign w_zmin = ZW'($signed(i_cfg.z_limits[23:0]));
    assign w_zmax = ZW'($signed(i_cfg.z_limits[47:24]));
    assign w_z3   = ZW'(r_crd3[2]);

    assign w_d2   = DW'(r_sq4[0]) + DW'(r_sq4[1]) + DW'(r_sq4[2]);
    assign w_keep = r_zok4 && (w_d2 >= DW'(i_cfg.min_range_sq))
                 && (w_d2 <= DW'(i_cfg.max_range_sq));

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            for (int i = 0; i < 3; i++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[i][c] <= w_coef[i][c] * w_pt[c];
                end
            end
            r_rel1 <= i_q_data[3*CW +: REL_W];
            r_str1 <= i_q_data[3*CW+REL_W +: STRENGTH_W];
        end
        if (w_rdy2) begin
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= AW'(r_prod[i][0]) + AW'(r_prod[i][1])
                          + AW'(r_prod[i][2]) + RND_HALF;
            end
            r_rel2 <= r_rel1;
            r_str2 <= r_str1;
        end
        if (w_rdy3) begin
            r_crd3 <= w_sat;
            r_rel3 <= r_rel2;
            r_str3 <= r_str2;
        end
        if (w_rdy4) begin
            for (int i = 0; i < 3; i++) begin
                r_sq4[i] <= QW'(w_mag[i]) * QW'(w_mag[i]);
            end
            r_crd4 <= r_crd3;
            r_zok4 <= (w_z3 >= w_zmin) && (w_z3 <= w_zmax);
            r_rel4 <= r_rel3;
            r_str4 <= r_str3;
        end
        if (w_en_out && r_v4 && w_keep) begin
            r_ocrd <= r_crd4;
            r_orel <= r_rel4;
            r_ostr <= r_str4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_q_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
            if (w_en_out) begin
                r_ov <= r_v4 && w_keep;
            end
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.x_out        = r_ocrd[0];
    assign o_res.y_out        = r_ocrd[1];
    assign o_res.z_out        = r_ocrd[2];
    assign o_res.strength_out = r_ostr;
    assign o_res.rel_time_ns  = r_orel;

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_v4))
        else $error("result appeared without a point in the last stage");

endmodule

@@ verif/tb_lidar_point_filter_transform.sv @@
`timescale 1ns / 1ps

module tb_lidar_point_filter_transform;
    import lpft_pkg::*;

    // run bounds
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  SETTLE_CYCLES = 12;        // margin for dropped points to clear
    localparam int  PHASE_POINTS  = 190;
    localparam int  HOLD_CYCLES   = 300;

    // coordinate and rounding constants at the default geometry
    localparam longint COORD_MAX  = (longint'(1) << (COORD_WIDTH_DEF - 1)) - 1;
    localparam longint COORD_MIN  = -COORD_MAX - 1;
    localparam longint ROUND_HALF = longint'(1) << (COEF_FRAC_BITS_DEF - 1);
    localparam logic [63:0] REL_MAX = 64'h0000_0000_FFFF_FFFF;

    // one lidar point as offered on the input channel
    typedef struct packed {
        logic                  frame_start;
        logic signed [23:0]    x;
        logic signed [23:0]    y;
        logic signed [23:0]    z;
        logic [7:0]            refl;
        logic [7:0]            tag;
        logic [7:0]            line;
        logic [63:0]           stamp;
    } pt_t;

    // one transformed point as delivered on the result channel
    typedef struct packed {
        logic signed [23:0]    x;
        logic signed [23:0]    y;
        logic signed [23:0]    z;
        logic [7:0]            strength;
        logic [31:0]           rel_ns;
    } point_res_t;

    // mirrors the block's registers and decimation state, predicts each surviving point
    class point_scoreboard;
        logic [47:0] rot_row [3];
        logic [47:0] offset_xyz;
        logic [35:0] range_lo;
        logic [35:0] range_hi;
        logic [47:0] z_window;
        logic [7:0]  keep_every;
        logic [7:0]  skip_phase;
        logic [63:0] base_stamp;
        point_res_t  due_pts [$];
        int          mismatches;
        int          matched;
        int          accepted;

        function new();
            rot_row[0] = RST_ROT_ROW0;
            rot_row[1] = RST_ROT_ROW1;
            rot_row[2] = RST_ROT_ROW2;
            offset_xyz = RST_TRANSLATION;
            range_lo   = RST_MIN_RANGE;
            range_hi   = RST_MAX_RANGE;
            z_window   = RST_Z_LIMITS;
            keep_every = RST_DECIMATION;
            skip_phase = 8'd0;
            base_stamp = 64'd0;
            mismatches = 0;
            matched    = 0;
            accepted   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ROT_ROW0:    rot_row[0] = data;
                CFG_ROT_ROW1:    rot_row[1] = data;
                CFG_ROT_ROW2:    rot_row[2] = data;
                CFG_TRANSLATION: offset_xyz = data;
                CFG_MIN_RANGE:   range_lo   = data[35:0];
                CFG_MAX_RANGE:   range_hi   = data[35:0];
                CFG_Z_LIMITS:    z_window   = data;
                CFG_DECIMATION:  keep_every = data[7:0];
                default: ;
            endcase
        endfunction

        function int due_count();
            return due_pts.size();
        endfunction

        // accepted point: advance decimation, filter, transform, queue the expected result
        function void note_point(pt_t p);
            logic [7:0]      step_div;
            logic [8:0]      next_phase;
            bit              chosen;
            longint          pos [3];
            longint          moved [3];
            longint          acc;
            longint unsigned range_sq;
            longint          zlo;
            longint          zhi;
            logic [63:0]     span;
            point_res_t      res;
            int              i;
            int              c;

            accepted++;
            step_div = (keep_every == 8'd0) ? 8'd1 : keep_every;
            if (p.frame_start) begin
                skip_phase = 8'd0;
                base_stamp = p.stamp;
            end
            chosen     = (skip_phase == 8'd0);
            next_phase = {1'b0, skip_phase} + 9'd1;
            skip_phase = (next_phase >= {1'b0, step_div}) ? 8'd0 : next_phase[7:0];

            if (!chosen || p.line >= LINE_LIMIT)
                return;
            if ((p.tag & TAG_QUAL_MASK) != TAG_QUAL_HIGH &&
                (p.tag & TAG_QUAL_MASK) != TAG_QUAL_NORM)
                return;

            pos[0] = longint'($signed(p.x));
            pos[1] = longint'($signed(p.y));
            pos[2] = longint'($signed(p.z));
            for (i = 0; i < 3; i++) begin
                acc = 0;
                for (c = 0; c < 3; c++)
                    acc += longint'($signed(rot_row[i][16*c +: 16])) * pos[c];
                acc = (acc + ROUND_HALF) >>> COEF_FRAC_BITS_DEF;
                acc += longint'($signed(offset_xyz[16*i +: 16]));
                if (acc > COORD_MAX)
                    acc = COORD_MAX;
                else if (acc < COORD_MIN)
                    acc = COORD_MIN;
                moved[i] = acc;
            end

            // saturated coordinates stay below 2^48 when squared and summed
            range_sq = moved[0] * moved[0] + moved[1] * moved[1] + moved[2] * moved[2];
            zlo  = longint'($signed(z_window[23:0]));
            zhi  = longint'($signed(z_window[47:24]));
            if (range_sq < range_lo || range_sq > range_hi || moved[2] < zlo || moved[2] > zhi)
                return;

            if (p.stamp < base_stamp)
                span = 64'd0;
            else begin
                span = p.stamp - base_stamp;
                if (span > REL_MAX)
                    span = REL_MAX;
            end

            res.x        = moved[0][23:0];
            res.y        = moved[1][23:0];
            res.z        = moved[2][23:0];
            res.strength = p.refl;
            res.rel_ns   = span[31:0];
            due_pts = {due_pts, res};
        endfunction

        // delivered point: compare with the oldest prediction
        function void check_result(point_res_t got);
            point_res_t want;

            if (due_pts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected point x=%0d y=%0d z=%0d s=%0d t=%0d", $realtime,
                             got.x, got.y, got.z, got.strength, got.rel_ns);
                return;
            end
            want = due_pts.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.strength !== want.strength || got.rel_ns !== want.rel_ns) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] point differs", $realtime);
                    $display("    exp x=%0d y=%0d z=%0d s=%0d t=%0d",
                             want.x, want.y, want.z, want.strength, want.rel_ns);
                    $display("    got x=%0d y=%0d z=%0d s=%0d t=%0d",
                             got.x, got.y, got.z, got.strength, got.rel_ns);
                end
            end else
                matched++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lpft_cfg_if cfg_bus ();
    lpft_pt_if  pt_bus ();
    lpft_res_if res_bus ();

    lidar_point_filter_transform i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pt    (pt_bus),
        .o_res   (res_bus)
    );

    point_scoreboard sb = new();

    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_req;
    int          hold_left;
    int          cycle_count;
    int          settings_applied;
    logic [63:0] stamp_now;
    point_res_t  seen_res;

    // 4 ns clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // watchdog, counted in clock cycles
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side back-pressure: random stalls, or a long hold when asked for
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            res_bus.ready = 1'b0;
            hold_left--;
        end else
            res_bus.ready = ($urandom_range(99) >= rx_idle_pct);
    end

    // every result request is checked as it is taken
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            seen_res.x        = res_bus.x_out;
            seen_res.y        = res_bus.y_out;
            seen_res.z        = res_bus.z_out;
            seen_res.strength = res_bus.strength_out;
            seen_res.rel_ns   = res_bus.rel_time_ns;
            sb.check_result(seen_res);
        end
    end

    // one register write request; the block is idle whenever this is called
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        cfg_bus.valid = 1'b1;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    // offer one point, with random gaps first, and hold it until taken
    task automatic send_point(input pt_t p);
        while ($urandom_range(99) < tx_idle_pct) begin
            pt_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        pt_bus.frame_start  = p.frame_start;
        pt_bus.x_in         = p.x;
        pt_bus.y_in         = p.y;
        pt_bus.z_in         = p.z;
        pt_bus.reflectivity = p.refl;
        pt_bus.point_tag    = p.tag;
        pt_bus.scan_line    = p.line;
        pt_bus.stamp_ns     = p.stamp;
        pt_bus.valid        = 1'b1;
        @(posedge i_clk);
        while (!pt_bus.ready)
            @(posedge i_clk);
        sb.note_point(p);
        @(negedge i_clk);
    endtask

    // stop offering, wait for every predicted point, then let dropped ones clear
    task automatic drain();
        pt_bus.valid = 1'b0;
        while (sb.due_count() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic pt_t mk_point(bit fs, int x, int y, int z, logic [7:0] refl,
                                     logic [7:0] tag, logic [7:0] line, logic [63:0] stamp);
        pt_t p;
        p.frame_start = fs;
        p.x           = x[23:0];
        p.y           = y[23:0];
        p.z           = z[23:0];
        p.refl        = refl;
        p.tag         = tag;
        p.line        = line;
        p.stamp       = stamp;
        return p;
    endfunction

    // mostly within a few tens of metres so points survive the range check
    function automatic logic [23:0] rand_coord();
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 60)
            v = int'($urandom_range(65535)) - 32768;
        else if (pick < 85)
            v = int'($urandom_range(262143)) - 131072;
        else
            v = int'($urandom);
        return v[23:0];
    endfunction

    // well-formed points with random content, plus some noise
    function automatic pt_t rand_point();
        pt_t         p;
        int          pick;
        logic [31:0] bits;

        pick = $urandom_range(99);
        if (pick < 90)
            stamp_now = stamp_now + 64'($urandom_range(1, 2000));
        else if (pick < 94)
            stamp_now = stamp_now - 64'($urandom_range(1, 5000));
        else if (pick < 97)
            stamp_now = stamp_now + 64'h1_0000_0000 + 64'($urandom);
        else
            stamp_now = {$urandom, $urandom};

        bits          = $urandom;
        p.frame_start = ($urandom_range(99) < 4);
        p.x           = rand_coord();
        p.y           = rand_coord();
        p.z           = rand_coord();
        p.refl        = bits[7:0];
        p.stamp       = stamp_now;
        if ($urandom_range(99) < 80) begin
            p.line = 8'($urandom_range(3));
            p.tag  = {bits[15:14], 1'b0, bits[12:8]};
        end else begin
            p.line = bits[23:16];
            p.tag  = bits[31:24];
        end
        return p;
    endfunction

    // register settings for the random phases, extremes among them
    task automatic apply_setting(input int k);
        logic [35:0] lo;
        int          zl;
        int          zh;

        settings_applied++;
        case (k)
            0: begin
                // reset values written back explicitly
                cfg_write(CFG_ROT_ROW0, RST_ROT_ROW0);
                cfg_write(CFG_ROT_ROW1, RST_ROT_ROW1);
                cfg_write(CFG_ROT_ROW2, RST_ROT_ROW2);
                cfg_write(CFG_TRANSLATION, RST_TRANSLATION);
                cfg_write(CFG_MIN_RANGE, 48'(RST_MIN_RANGE));
                cfg_write(CFG_MAX_RANGE, 48'(RST_MAX_RANGE));
                cfg_write(CFG_Z_LIMITS, RST_Z_LIMITS);
                cfg_write(CFG_DECIMATION, 48'(RST_DECIMATION));
            end
            1: begin
                // largest positive coefficients and offsets
                cfg_write(CFG_ROT_ROW0, {3{16'h7FFF}});
                cfg_write(CFG_ROT_ROW1, {3{16'h7FFF}});
                cfg_write(CFG_ROT_ROW2, {3{16'h7FFF}});
                cfg_write(CFG_TRANSLATION, {3{16'h7FFF}});
                cfg_write(CFG_DECIMATION, 48'd2);
            end
            2: begin
                // most negative coefficients and offsets
                cfg_write(CFG_ROT_ROW0, {3{16'h8000}});
                cfg_write(CFG_ROT_ROW1, {3{16'h8000}});
                cfg_write(CFG_ROT_ROW2, {3{16'h8000}});
                cfg_write(CFG_TRANSLATION, {3{16'h8000}});
                cfg_write(CFG_DECIMATION, 48'd1);
            end
            3: begin
                // random transform inside a random window
                lo = 36'($urandom_range(1 << 26));
                zl = -int'($urandom_range(131072));
                zh = int'($urandom_range(131072));
                cfg_write(CFG_ROT_ROW0, {$urandom, $urandom});
                cfg_write(CFG_ROT_ROW1, {$urandom, $urandom});
                cfg_write(CFG_ROT_ROW2, {$urandom, $urandom});
                cfg_write(CFG_TRANSLATION, {$urandom, $urandom});
                cfg_write(CFG_MIN_RANGE, 48'(lo));
                cfg_write(CFG_MAX_RANGE, 48'(lo + {4'd0, 32'($urandom_range(1 << 20, 32'h7FFF_FFFF))}));
                cfg_write(CFG_Z_LIMITS, {zh[23:0], zl[23:0]});
                cfg_write(CFG_DECIMATION, 48'($urandom_range(1, 6)));
            end
            4: begin
                // range window inverted, nothing survives
                cfg_write(CFG_ROT_ROW0, RST_ROT_ROW0);
                cfg_write(CFG_ROT_ROW1, RST_ROT_ROW1);
                cfg_write(CFG_ROT_ROW2, RST_ROT_ROW2);
                cfg_write(CFG_TRANSLATION, RST_TRANSLATION);
                cfg_write(CFG_MIN_RANGE, 48'h0_4000_0000);
                cfg_write(CFG_MAX_RANGE, 48'h0_0010_0000);
                cfg_write(CFG_Z_LIMITS, RST_Z_LIMITS);
                cfg_write(CFG_DECIMATION, 48'd1);
            end
            5: begin
                // z window inverted, range open again
                zl = 1000;
                zh = -1000;
                cfg_write(CFG_MIN_RANGE, 48'(RST_MIN_RANGE));
                cfg_write(CFG_MAX_RANGE, 48'(RST_MAX_RANGE));
                cfg_write(CFG_Z_LIMITS, {zh[23:0], zl[23:0]});
            end
            6: begin
                // heaviest decimation, random offsets
                cfg_write(CFG_Z_LIMITS, RST_Z_LIMITS);
                cfg_write(CFG_TRANSLATION, {$urandom, $urandom});
                cfg_write(CFG_DECIMATION, 48'd255);
            end
            default: begin
                // random rotation, decimation zero acts as one
                cfg_write(CFG_ROT_ROW0, {$urandom, $urandom});
                cfg_write(CFG_ROT_ROW1, {$urandom, $urandom});
                cfg_write(CFG_ROT_ROW2, {$urandom, $urandom});
                cfg_write(CFG_TRANSLATION, {$urandom, $urandom});
                cfg_write(CFG_DECIMATION, 48'd0);
            end
        endcase
    endtask

    initial begin
        int k;
        int n;

        // every input known from the start
        i_rst_n             = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = CFG_ROT_ROW0;
        cfg_bus.data        = '0;
        pt_bus.valid        = 1'b0;
        pt_bus.frame_start  = 1'b0;
        pt_bus.x_in         = '0;
        pt_bus.y_in         = '0;
        pt_bus.z_in         = '0;
        pt_bus.reflectivity = '0;
        pt_bus.point_tag    = '0;
        pt_bus.scan_line    = '0;
        pt_bus.stamp_ns     = '0;
        res_bus.ready       = 1'b0;
        hold_req            = 1'b0;
        hold_left           = 0;
        cycle_count         = 0;
        settings_applied    = 0;
        stamp_now           = 64'd100_000;

        // sender idles a little, receiver a lot
        tx_idle_pct = 23;
        rx_idle_pct = 74;

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings, identity transform
        // no frame seen yet, base is zero
        send_point(mk_point(0, 1000, -2000, 300, 8'd0, 8'h00, 8'd0, 64'd1000));
        // frame start on the last permitted line
        send_point(mk_point(1, 100, 200, -300, 8'd255, 8'h10, 8'd3, 64'd5000));
        // stamp before the base, quality bits clear with the others set
        send_point(mk_point(0, -50, 60, 70, 8'd17, 8'hCF, 8'd0, 64'd4000));
        // offset too large for 32 bits
        send_point(mk_point(0, 5, 6, 7, 8'd1, 8'h1F, 8'd1, 64'd5000 + 64'h2_0000_0000));
        // rejected quality codes and lines
        send_point(mk_point(0, 5, 6, 7, 8'd2, 8'h20, 8'd0, 64'd6000));
        send_point(mk_point(0, 5, 6, 7, 8'd3, 8'h30, 8'd0, 64'd6001));
        send_point(mk_point(0, 5, 6, 7, 8'd4, 8'h00, 8'd4, 64'd6002));
        send_point(mk_point(0, 5, 6, 7, 8'd5, 8'h00, 8'd255, 64'd6003));
        // coordinate extremes fall outside the default range
        send_point(mk_point(0, 8388607, -8388608, -8388608, 8'd6, 8'h00, 8'd0, 64'd6004));
        send_point(mk_point(0, -8388608, 8388607, 8388607, 8'd7, 8'h10, 8'd1, 64'd6005));
        // base latched by a frame start that is itself dropped
        send_point(mk_point(1, 1, 2, 3, 8'd8, 8'h00, 8'd4, 64'd9000));
        send_point(mk_point(0, 1, 2, 3, 8'd99, 8'h00, 8'd2, 64'd9500));
        send_point(mk_point(0, 1, 2, 3, 8'd98, 8'h00, 8'd2, 64'hFFFF_FFFF_FFFF_FFFF));

        // directed: rounding half up with the smallest coefficient
        drain();
        cfg_write(CFG_ROT_ROW0, {16'd0, 16'd0, 16'd1});
        cfg_write(CFG_ROT_ROW1, {16'd0, 16'd1, 16'd0});
        cfg_write(CFG_ROT_ROW2, {16'd1, 16'd0, 16'd0});
        send_point(mk_point(0, 8192, -8192, -8193, 8'd11, 8'h00, 8'd0, 64'd9600));
        send_point(mk_point(0, 24576, -8191, 8191, 8'd12, 8'h10, 8'd1, 64'd9700));

        // directed: decimation lowered while the count is past the new value
        drain();
        cfg_write(CFG_DECIMATION, 48'd5);
        send_point(mk_point(1, 10, 10, 10, 8'd21, 8'h00, 8'd0, 64'd20000));
        send_point(mk_point(0, 11, 11, 11, 8'd22, 8'h00, 8'd0, 64'd20010));
        send_point(mk_point(0, 12, 12, 12, 8'd23, 8'h00, 8'd0, 64'd20020));
        drain();
        cfg_write(CFG_DECIMATION, 48'd2);
        send_point(mk_point(0, 13, 13, 13, 8'd24, 8'h00, 8'd0, 64'd20030));
        send_point(mk_point(0, 14, 14, 14, 8'd25, 8'h00, 8'd0, 64'd20040));
        send_point(mk_point(0, 15, 15, 15, 8'd26, 8'h00, 8'd0, 64'd20050));

        // random phases, one register setting each
        for (k = 0; k < 8; k++) begin
            drain();
            apply_setting(k);
            if (k < 3) begin
                tx_idle_pct = 23;
                rx_idle_pct = 74;
            end else if (k < 6) begin
                tx_idle_pct = 74;
                rx_idle_pct = 23;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (n = 0; n < PHASE_POINTS; n++) begin
                // sender pauses until the pipeline has emptied
                if (k == 1 && n == PHASE_POINTS / 2)
                    drain();
                // receiver holds off long enough for the input to stall
                if (k == 7 && n == 20)
                    hold_req = 1'b1;
                send_point(rand_point());
            end
        end

        drain();
        $display("covered %0d points over %0d register settings, %0d transformed points matched",
                 sb.accepted, settings_applied, sb.matched);
        $display("idle mixes on both sides, a long result stall and a full drain mid-stream");
        if (sb.due_count() != 0)
            $display("%0d predicted points never delivered", sb.due_count());
        if (sb.mismatches == 0 && sb.due_count() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
